@@ rtl/core/quadratic_biquadratic_solver_core_assert.svh @@
// assertion macros shared by the solver checker
// depends on nothing; included by qbs_chk.sv
`ifndef QUADRATIC_BIQUADRATIC_SOLVER_CORE_ASSERT_SVH
`define QUADRATIC_BIQUADRATIC_SOLVER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define QBS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// consequent after a fixed number of cycles, disabled in reset
`define QBS_ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("%m: assertion failed");

`endif

@@ rtl/core/qbs_pkg.sv @@
// shared types and constants of the quadratic/biquadratic solver
// no dependencies; used by the top level and the checker
`timescale 1ns / 1ps
`default_nettype none

package qbs_pkg;

  localparam int COEF_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int OUTCOME_W      = 2;
  localparam int COUNT_W        = 3;

  // result outcome codes
  typedef enum logic [OUTCOME_W-1:0] {
    OUT_FINITE = 2'd0,
    OUT_NONE   = 2'd1,
    OUT_ALL    = 2'd2
  } outcome_t;

  // case split of the quadratic step
  typedef enum logic [2:0] {
    CS_ALL,
    CS_NONE,
    CS_NEG,
    CS_LINEAR,
    CS_DOUBLE,
    CS_TWO
  } case_t;

endpackage

`default_nettype wire

@@ rtl/core/qbs_sqrt_pipe.sv @@
// pipelined integer square root, one root bit per register stage
// no dependencies; used by the solver top level
`timescale 1ns / 1ps
`default_nettype none

module qbs_sqrt_pipe #(
  parameter int RAD_WIDTH = 66,
  parameter int SB_WIDTH  = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  logic [RAD_WIDTH-1:0]   in_rad,
  input  logic [SB_WIDTH-1:0]    in_sb,
  output logic                   out_vld,
  output logic [RAD_WIDTH/2-1:0] out_root,
  output logic [SB_WIDTH-1:0]    out_sb
);

  localparam int ROOT_W = RAD_WIDTH / 2;
  localparam int REM_W  = ROOT_W + 3;

  logic                 vld_r  [ROOT_W];
  logic [RAD_WIDTH-1:0] rad_r  [ROOT_W];
  logic [REM_W-1:0]     rem_r  [ROOT_W];
  logic [ROOT_W-1:0]    root_r [ROOT_W];
  logic [SB_WIDTH-1:0]  sb_r   [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic                 vld_in;
    logic [RAD_WIDTH-1:0] rad_in;
    logic [REM_W-1:0]     rem_in;
    logic [ROOT_W-1:0]    root_in;
    logic [SB_WIDTH-1:0]  sb_in;
    logic [REM_W-1:0]     rem_sh;
    logic [REM_W-1:0]     trial;
    logic [REM_W-1:0]     rem_nxt;
    logic [ROOT_W-1:0]    root_nxt;
    logic [RAD_WIDTH-1:0] rad_nxt;

    if (i == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rad_in  = in_rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign sb_in   = in_sb;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign rad_in  = rad_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign sb_in   = sb_r[i-1];
    end

    // bring in two radicand bits, try root*4+1
    always_comb begin
      rem_sh  = {rem_in[REM_W-3:0], rad_in[RAD_WIDTH-1 -: 2]};
      trial   = REM_W'({root_in, 2'b01});
      rad_nxt = {rad_in[RAD_WIDTH-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_in[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rad_r[i]  <= rad_nxt;
      rem_r[i]  <= rem_nxt;
      root_r[i] <= root_nxt;
      sb_r[i]   <= sb_in;
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_root = root_r[ROOT_W-1];
  assign out_sb   = sb_r[ROOT_W-1];

endmodule

`default_nettype wire

@@ rtl/core/qbs_div_pipe.sv @@
// pipelined restoring divider with round half away from zero and saturation
// no dependencies; used by the solver top level
`timescale 1ns / 1ps
`default_nettype none

module qbs_div_pipe #(
  parameter int NUM_WIDTH = 50,
  parameter int DEN_WIDTH = 33,
  parameter int RES_WIDTH = 32,
  parameter int SB_WIDTH  = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic                        in_neg,
  input  logic [NUM_WIDTH-1:0]        in_num,
  input  logic [DEN_WIDTH-1:0]        in_den,
  input  logic [SB_WIDTH-1:0]         in_sb,
  output logic                        out_vld,
  output logic signed [RES_WIDTH-1:0] out_quo,
  output logic [SB_WIDTH-1:0]         out_sb
);

  localparam int REM_W = DEN_WIDTH + 1;
  localparam logic [NUM_WIDTH:0] POS_BOUND =
    {{(NUM_WIDTH-RES_WIDTH+2){1'b0}}, {(RES_WIDTH-1){1'b1}}};
  localparam logic [NUM_WIDTH:0] NEG_BOUND = POS_BOUND + 1'b1;

  logic                 vld_r [NUM_WIDTH];
  logic                 neg_r [NUM_WIDTH];
  logic [NUM_WIDTH-1:0] num_r [NUM_WIDTH];
  logic [DEN_WIDTH-1:0] den_r [NUM_WIDTH];
  logic [REM_W-1:0]     rem_r [NUM_WIDTH];
  logic [NUM_WIDTH-1:0] quo_r [NUM_WIDTH];
  logic [SB_WIDTH-1:0]  sb_r  [NUM_WIDTH];

  for (genvar i = 0; i < NUM_WIDTH; i++) begin : g_stage
    logic                 vld_in;
    logic                 neg_in;
    logic [NUM_WIDTH-1:0] num_in;
    logic [DEN_WIDTH-1:0] den_in;
    logic [REM_W-1:0]     rem_in;
    logic [NUM_WIDTH-1:0] quo_in;
    logic [SB_WIDTH-1:0]  sb_in;
    logic [REM_W-1:0]     rem_sh;
    logic [REM_W-1:0]     rem_nxt;
    logic [NUM_WIDTH-1:0] quo_nxt;

    if (i == 0) begin : g_first
      assign vld_in = in_vld;
      assign neg_in = in_neg;
      assign num_in = in_num;
      assign den_in = in_den;
      assign rem_in = '0;
      assign quo_in = '0;
      assign sb_in  = in_sb;
    end else begin : g_next
      assign vld_in = vld_r[i-1];
      assign neg_in = neg_r[i-1];
      assign num_in = num_r[i-1];
      assign den_in = den_r[i-1];
      assign rem_in = rem_r[i-1];
      assign quo_in = quo_r[i-1];
      assign sb_in  = sb_r[i-1];
    end

    // one quotient bit: shift in a numerator bit, subtract if it fits
    always_comb begin
      rem_sh = {rem_in[DEN_WIDTH-1:0], num_in[NUM_WIDTH-1]};
      if (rem_sh >= REM_W'(den_in)) begin
        rem_nxt = rem_sh - REM_W'(den_in);
        quo_nxt = {quo_in[NUM_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_in[NUM_WIDTH-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      neg_r[i] <= neg_in;
      num_r[i] <= {num_in[NUM_WIDTH-2:0], 1'b0};
      den_r[i] <= den_in;
      rem_r[i] <= rem_nxt;
      quo_r[i] <= quo_nxt;
      sb_r[i]  <= sb_in;
    end
  end

  // round on the remainder, then clamp the magnitude
  logic                 rnd_vld_r;
  logic                 rnd_neg_r;
  logic [RES_WIDTH-1:0] rnd_mag_r;
  logic [SB_WIDTH-1:0]  rnd_sb_r;
  logic                 round_up;
  logic [NUM_WIDTH:0]   quo_rnd;
  logic [NUM_WIDTH:0]   bound;
  logic [RES_WIDTH-1:0] mag_nxt;

  always_comb begin
    round_up = {rem_r[NUM_WIDTH-1][DEN_WIDTH-1:0], 1'b0} >= {1'b0, den_r[NUM_WIDTH-1]};
    quo_rnd  = {1'b0, quo_r[NUM_WIDTH-1]} + (NUM_WIDTH+1)'(round_up);
    bound    = neg_r[NUM_WIDTH-1] ? NEG_BOUND : POS_BOUND;
    mag_nxt  = (quo_rnd > bound) ? bound[RES_WIDTH-1:0] : quo_rnd[RES_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_vld_r <= 1'b0;
    end else begin
      rnd_vld_r <= vld_r[NUM_WIDTH-1];
    end
  end

  always_ff @(posedge clk) begin
    rnd_neg_r <= neg_r[NUM_WIDTH-1];
    rnd_mag_r <= mag_nxt;
    rnd_sb_r  <= sb_r[NUM_WIDTH-1];
  end

  // apply the sign
  logic                        out_vld_r;
  logic signed [RES_WIDTH-1:0] out_quo_r;
  logic [SB_WIDTH-1:0]         out_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= rnd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_quo_r <= rnd_neg_r ? $signed(-rnd_mag_r) : $signed(rnd_mag_r);
    out_sb_r  <= rnd_sb_r;
  end

  assign out_vld = out_vld_r;
  assign out_quo = out_quo_r;
  assign out_sb  = out_sb_r;

endmodule

`default_nettype wire

@@ rtl/core/quadratic_biquadratic_solver_core.sv @@
// top level of the real-root solver for quadratic and biquadratic equations
// depends on qbs_pkg, qbs_sqrt_pipe and qbs_div_pipe
//
// usage:
//   a request is taken at a rising edge with start high and busy low; busy
//   is always low, so a new equation can be sent every cycle. in_kind picks
//   a*x^2+b*x+c=0 (0) or a*x^4+b*x^2+c=0 (1); coefficients are signed
//   fixed point with FRAC_BITS fraction bits.
//   each request gives exactly one result, shown for one cycle with
//   out_valid high: outcome, root count and four roots, unused roots zero.
//   throughput is one equation per cycle. a request passes through the
//   discriminant square root (W+1 stages), the divider (W+F+4 stages) and
//   the half-root square root ((W+F)/2 stages); the square roots work one
//   bit per stage, the divider likewise but for its rounding and sign
//   stages. reset clears every valid bit, dropping requests in flight.
//   results cannot be held off by the receiver and the pipeline never
//   stalls.
`timescale 1ns / 1ps
`default_nettype none

module quadratic_biquadratic_solver_core #(
  parameter int COEF_WIDTH = qbs_pkg::COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = qbs_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_kind,
  input  logic signed [COEF_WIDTH-1:0]   in_coef_a,
  input  logic signed [COEF_WIDTH-1:0]   in_coef_b,
  input  logic signed [COEF_WIDTH-1:0]   in_coef_c,
  output logic                           out_valid,
  output logic [qbs_pkg::OUTCOME_W-1:0]  out_outcome,
  output logic [qbs_pkg::COUNT_W-1:0]    out_root_count,
  output logic signed [COEF_WIDTH-1:0]   out_root_one,
  output logic signed [COEF_WIDTH-1:0]   out_root_two,
  output logic signed [COEF_WIDTH-1:0]   out_root_three,
  output logic signed [COEF_WIDTH-1:0]   out_root_four
);

  import qbs_pkg::*;

  localparam int W       = COEF_WIDTH;
  localparam int F       = FRAC_BITS;
  localparam int DW      = 2 * W + 2;
  localparam int SW      = DW / 2;
  localparam int NBW     = W + 3;
  localparam int NW      = W + 2 + F;
  localparam int DENW    = W + 1;
  localparam int HRW     = ((W + F) / 2) * 2;
  localparam int HOW     = HRW / 2;
  localparam int CW      = (HOW > W) ? HOW : W;
  localparam int LATENCY = 2 * W + F + 12 + (W + F) / 2;
  localparam logic [W-1:0] HMAX = {1'b0, {(W-1){1'b1}}};

  typedef struct packed {
    logic         kind;
    case_t        cs;
    logic         an;
    logic         bn;
    logic         cn;
    logic [W-1:0] am;
    logic [W-1:0] bm;
    logic [W-1:0] cm;
  } sb1_t;

  typedef struct packed {
    case_t        cs;
    logic [W-1:0] x;
  } sbh0_t;

  typedef struct packed {
    logic         kind;
    logic [W-1:0] x;
  } sbh1_t;

  // pipeline takes a request every cycle
  assign busy = 1'b0;

  // stage 1: sign and magnitude of the coefficients
  logic         s1_vld_r;
  logic         s1_kind_r;
  logic         s1_an_r;
  logic         s1_bn_r;
  logic         s1_cn_r;
  logic [W-1:0] s1_am_r;
  logic [W-1:0] s1_bm_r;
  logic [W-1:0] s1_cm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_kind_r <= in_kind;
    s1_an_r   <= in_coef_a[W-1];
    s1_bn_r   <= in_coef_b[W-1];
    s1_cn_r   <= in_coef_c[W-1];
    s1_am_r   <= in_coef_a[W-1] ? (~$unsigned(in_coef_a) + 1'b1) : $unsigned(in_coef_a);
    s1_bm_r   <= in_coef_b[W-1] ? (~$unsigned(in_coef_b) + 1'b1) : $unsigned(in_coef_b);
    s1_cm_r   <= in_coef_c[W-1] ? (~$unsigned(in_coef_c) + 1'b1) : $unsigned(in_coef_c);
  end

  // stage 2: b*b and a*c
  logic           s2_vld_r;
  logic           s2_kind_r;
  logic           s2_an_r;
  logic           s2_bn_r;
  logic           s2_cn_r;
  logic [W-1:0]   s2_am_r;
  logic [W-1:0]   s2_bm_r;
  logic [W-1:0]   s2_cm_r;
  logic [2*W-1:0] s2_p_r;
  logic [2*W-1:0] s2_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_kind_r <= s1_kind_r;
    s2_an_r   <= s1_an_r;
    s2_bn_r   <= s1_bn_r;
    s2_cn_r   <= s1_cn_r;
    s2_am_r   <= s1_am_r;
    s2_bm_r   <= s1_bm_r;
    s2_cm_r   <= s1_cm_r;
    s2_p_r    <= s1_bm_r * s1_bm_r;
    s2_q_r    <= s1_am_r * s1_cm_r;
  end

  // stage 3: discriminant and case split
  logic          s3_vld_r;
  logic [DW-1:0] s3_d_r;
  sb1_t          s3_sb_r;
  logic [DW-1:0] p_ext;
  logic [DW-1:0] q4;
  logic [DW-1:0] d_nxt;
  case_t         cs_nxt;

  always_comb begin
    p_ext  = DW'(s2_p_r);
    q4     = {s2_q_r, 2'b00};
    d_nxt  = '0;
    cs_nxt = CS_NEG;
    if (s2_am_r == '0) begin
      if (s2_bm_r == '0) begin
        cs_nxt = (s2_cm_r == '0) ? CS_ALL : CS_NONE;
      end else begin
        cs_nxt = CS_LINEAR;
      end
    end else if (s2_an_r == s2_cn_r) begin
      if (p_ext < q4) begin
        cs_nxt = CS_NEG;
      end else begin
        d_nxt  = p_ext - q4;
        cs_nxt = (d_nxt == '0) ? CS_DOUBLE : CS_TWO;
      end
    end else begin
      d_nxt  = p_ext + q4;
      cs_nxt = (d_nxt == '0) ? CS_DOUBLE : CS_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_d_r          <= d_nxt;
    s3_sb_r.kind    <= s2_kind_r;
    s3_sb_r.cs      <= cs_nxt;
    s3_sb_r.an      <= s2_an_r;
    s3_sb_r.bn      <= s2_bn_r;
    s3_sb_r.cn      <= s2_cn_r;
    s3_sb_r.am      <= s2_am_r;
    s3_sb_r.bm      <= s2_bm_r;
    s3_sb_r.cm      <= s2_cm_r;
  end

  // square root of the discriminant
  logic                    r1_vld;
  logic [SW-1:0]           r1_root;
  logic [$bits(sb1_t)-1:0] r1_sb_vec;
  sb1_t                    r1_sb;

  qbs_sqrt_pipe #(
    .RAD_WIDTH (DW),
    .SB_WIDTH  ($bits(sb1_t))
  ) u_disc_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s3_vld_r),
    .in_rad   (s3_d_r),
    .in_sb    (s3_sb_r),
    .out_vld  (r1_vld),
    .out_root (r1_root),
    .out_sb   (r1_sb_vec)
  );

  assign r1_sb = sb1_t'(r1_sb_vec);

  // stage 4: numerators -b - s and -b + s
  logic                  s4_vld_r;
  sb1_t                  s4_sb_r;
  logic signed [NBW-1:0] s4_n1_r;
  logic signed [NBW-1:0] s4_n2_r;
  logic signed [NBW-1:0] neg_b;
  logic signed [NBW-1:0] s_ext;

  always_comb begin
    neg_b = r1_sb.bn ? $signed({3'b000, r1_sb.bm}) : -$signed({3'b000, r1_sb.bm});
    s_ext = $signed({2'b00, r1_root});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= r1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s4_sb_r <= r1_sb;
    s4_n1_r <= neg_b - s_ext;
    s4_n2_r <= neg_b + s_ext;
  end

  // stage 5: divider operands for the case at hand
  logic            s5_vld_r;
  logic            s5_kind_r;
  case_t           s5_cs_r;
  logic            s5_neg0_r;
  logic            s5_neg1_r;
  logic [NW-1:0]   s5_num0_r;
  logic [NW-1:0]   s5_num1_r;
  logic [DENW-1:0] s5_den0_r;
  logic [DENW-1:0] s5_den1_r;
  logic [NBW-1:0]  n1_abs;
  logic [NBW-1:0]  n2_abs;
  logic [DENW-1:0] two_a;
  logic            neg0_nxt;
  logic [NW-1:0]   num0_nxt;
  logic [DENW-1:0] den0_nxt;

  always_comb begin
    n1_abs = s4_n1_r[NBW-1] ? $unsigned(-s4_n1_r) : $unsigned(s4_n1_r);
    n2_abs = s4_n2_r[NBW-1] ? $unsigned(-s4_n2_r) : $unsigned(s4_n2_r);
    two_a  = {s4_sb_r.am, 1'b0};
    case (s4_sb_r.cs)
      CS_LINEAR: begin
        neg0_nxt = (s4_sb_r.cn == s4_sb_r.bn);
        num0_nxt = NW'({s4_sb_r.cm, {F{1'b0}}});
        den0_nxt = DENW'(s4_sb_r.bm);
      end
      CS_DOUBLE: begin
        neg0_nxt = (s4_sb_r.bn == s4_sb_r.an);
        num0_nxt = NW'({s4_sb_r.bm, {F{1'b0}}});
        den0_nxt = two_a;
      end
      default: begin
        neg0_nxt = s4_n1_r[NBW-1] != s4_sb_r.an;
        num0_nxt = {n1_abs[NBW-2:0], {F{1'b0}}};
        den0_nxt = two_a;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_kind_r <= s4_sb_r.kind;
    s5_cs_r   <= s4_sb_r.cs;
    s5_neg0_r <= neg0_nxt;
    s5_num0_r <= num0_nxt;
    s5_den0_r <= den0_nxt;
    s5_neg1_r <= s4_n2_r[NBW-1] != s4_sb_r.an;
    s5_num1_r <= {n2_abs[NBW-2:0], {F{1'b0}}};
    s5_den1_r <= two_a;
  end

  // the two quotients
  logic                     d0_vld;
  logic signed [W-1:0]      d0_x;
  logic [$bits(case_t)-1:0] d0_sb;
  logic signed [W-1:0]      d1_x;
  logic                     d1_kind;

  qbs_div_pipe #(
    .NUM_WIDTH (NW),
    .DEN_WIDTH (DENW),
    .RES_WIDTH (W),
    .SB_WIDTH  ($bits(case_t))
  ) u_div_first (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s5_vld_r),
    .in_neg  (s5_neg0_r),
    .in_num  (s5_num0_r),
    .in_den  (s5_den0_r),
    .in_sb   (s5_cs_r),
    .out_vld (d0_vld),
    .out_quo (d0_x),
    .out_sb  (d0_sb)
  );

  qbs_div_pipe #(
    .NUM_WIDTH (NW),
    .DEN_WIDTH (DENW),
    .RES_WIDTH (W),
    .SB_WIDTH  (1)
  ) u_div_second (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s5_vld_r),
    .in_neg  (s5_neg1_r),
    .in_num  (s5_num1_r),
    .in_den  (s5_den1_r),
    .in_sb   (s5_kind_r),
    .out_vld (),
    .out_quo (d1_x),
    .out_sb  (d1_kind)
  );

  // square roots of the positive quadratic roots, scaled by 2^F
  logic [HRW-1:0] h0_rad;
  logic [HRW-1:0] h1_rad;
  sbh0_t          h0_sb_in;
  sbh1_t          h1_sb_in;

  always_comb begin
    h0_rad = (!d0_x[W-1] && d0_x != '0) ? HRW'({d0_x[W-2:0], {F{1'b0}}}) : '0;
    h1_rad = (!d1_x[W-1] && d1_x != '0) ? HRW'({d1_x[W-2:0], {F{1'b0}}}) : '0;
    h0_sb_in.cs   = case_t'(d0_sb);
    h0_sb_in.x    = d0_x;
    h1_sb_in.kind = d1_kind;
    h1_sb_in.x    = d1_x;
  end

  logic                     h0_vld;
  logic [HOW-1:0]           h0_root;
  logic [HOW-1:0]           h1_root;
  logic [$bits(sbh0_t)-1:0] h0_sb_vec;
  logic [$bits(sbh1_t)-1:0] h1_sb_vec;
  sbh0_t                    h0_sb;
  sbh1_t                    h1_sb;

  qbs_sqrt_pipe #(
    .RAD_WIDTH (HRW),
    .SB_WIDTH  ($bits(sbh0_t))
  ) u_half_sqrt_first (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (d0_vld),
    .in_rad   (h0_rad),
    .in_sb    (h0_sb_in),
    .out_vld  (h0_vld),
    .out_root (h0_root),
    .out_sb   (h0_sb_vec)
  );

  qbs_sqrt_pipe #(
    .RAD_WIDTH (HRW),
    .SB_WIDTH  ($bits(sbh1_t))
  ) u_half_sqrt_second (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (d0_vld),
    .in_rad   (h1_rad),
    .in_sb    (h1_sb_in),
    .out_vld  (),
    .out_root (h1_root),
    .out_sb   (h1_sb_vec)
  );

  assign h0_sb = sbh0_t'(h0_sb_vec);
  assign h1_sb = sbh1_t'(h1_sb_vec);

  // stage 7: clamp the half roots
  logic                s7_vld_r;
  logic                s7_kind_r;
  case_t               s7_cs_r;
  logic signed [W-1:0] s7_x0_r;
  logic signed [W-1:0] s7_x1_r;
  logic [W-1:0]        s7_h0_r;
  logic [W-1:0]        s7_h1_r;
  logic [CW-1:0]       h0_ext;
  logic [CW-1:0]       h1_ext;

  always_comb begin
    h0_ext = CW'(h0_root);
    h1_ext = CW'(h1_root);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else begin
      s7_vld_r <= h0_vld;
    end
  end

  always_ff @(posedge clk) begin
    s7_kind_r <= h1_sb.kind;
    s7_cs_r   <= h0_sb.cs;
    s7_x0_r   <= $signed(h0_sb.x);
    s7_x1_r   <= $signed(h1_sb.x);
    s7_h0_r   <= (h0_ext > CW'(HMAX)) ? HMAX : h0_ext[W-1:0];
    s7_h1_r   <= (h1_ext > CW'(HMAX)) ? HMAX : h1_ext[W-1:0];
  end

  // stage 8: root set and result register
  logic                out_valid_r;
  outcome_t            out_outcome_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic signed [W-1:0] out_r1_r;
  logic signed [W-1:0] out_r2_r;
  logic signed [W-1:0] out_r3_r;
  logic signed [W-1:0] out_r4_r;
  outcome_t            outcome_nxt;
  logic [COUNT_W-1:0]  count_nxt;
  logic signed [W-1:0] r1_nxt;
  logic signed [W-1:0] r2_nxt;
  logic signed [W-1:0] r3_nxt;
  logic signed [W-1:0] r4_nxt;
  logic signed [W-1:0] ph0;
  logic signed [W-1:0] ph1;
  logic signed [W-1:0] nh0;
  logic signed [W-1:0] nh1;
  logic                pos0;
  logic                pos1;
  logic                zero0;
  logic                zero1;

  always_comb begin
    ph0         = $signed(s7_h0_r);
    ph1         = $signed(s7_h1_r);
    nh0         = -ph0;
    nh1         = -ph1;
    zero0       = (s7_x0_r == '0);
    zero1       = (s7_x1_r == '0);
    pos0        = !s7_x0_r[W-1] && !zero0;
    pos1        = !s7_x1_r[W-1] && !zero1;
    outcome_nxt = OUT_FINITE;
    count_nxt   = 3'd0;
    r1_nxt      = '0;
    r2_nxt      = '0;
    r3_nxt      = '0;
    r4_nxt      = '0;
    case (s7_cs_r)
      CS_ALL: begin
        outcome_nxt = OUT_ALL;
      end
      CS_NONE: begin
        outcome_nxt = OUT_NONE;
      end
      CS_LINEAR, CS_DOUBLE: begin
        if (!s7_kind_r) begin
          count_nxt = 3'd1;
          r1_nxt    = s7_x0_r;
        end else if (pos0) begin
          count_nxt = 3'd2;
          r1_nxt    = ph0;
          r2_nxt    = nh0;
        end else if (zero0) begin
          count_nxt = 3'd1;
        end
      end
      CS_TWO: begin
        if (!s7_kind_r) begin
          count_nxt = 3'd2;
          r1_nxt    = s7_x0_r;
          r2_nxt    = s7_x1_r;
        end else if (pos0) begin
          if (pos1) begin
            count_nxt = 3'd4;
            r1_nxt    = ph0;
            r2_nxt    = ph1;
            r3_nxt    = nh0;
            r4_nxt    = nh1;
          end else if (zero1) begin
            count_nxt = 3'd3;
            r1_nxt    = ph0;
            r3_nxt    = nh0;
          end else begin
            count_nxt = 3'd2;
            r1_nxt    = ph0;
            r2_nxt    = nh0;
          end
        end else if (zero0) begin
          if (pos1) begin
            count_nxt = 3'd3;
            r2_nxt    = ph1;
            r3_nxt    = nh1;
          end else begin
            count_nxt = 3'd1;
          end
        end else if (pos1) begin
          count_nxt = 3'd2;
          r1_nxt    = nh1;
          r2_nxt    = ph1;
        end else if (zero1) begin
          count_nxt = 3'd1;
        end
      end
      default: begin
        count_nxt = 3'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s7_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_outcome_r <= outcome_nxt;
    out_count_r   <= count_nxt;
    out_r1_r      <= r1_nxt;
    out_r2_r      <= r2_nxt;
    out_r3_r      <= r3_nxt;
    out_r4_r      <= r4_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_outcome    = out_outcome_r;
  assign out_root_count = out_count_r;
  assign out_root_one   = out_r1_r;
  assign out_root_two   = out_r2_r;
  assign out_root_three = out_r3_r;
  assign out_root_four  = out_r4_r;

endmodule

`default_nettype wire

@@ rtl/core/qbs_chk.sv @@
// port-level checker for the solver, bound to the top level
// depends on qbs_pkg and quadratic_biquadratic_solver_core_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "quadratic_biquadratic_solver_core_assert.svh"

module qbs_prop_chk #(
  parameter int COEF_WIDTH = qbs_pkg::COEF_WIDTH_DEF,
  parameter int LATENCY    = 116
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [qbs_pkg::OUTCOME_W-1:0] out_outcome,
  input logic [qbs_pkg::COUNT_W-1:0]   out_root_count,
  input logic [COEF_WIDTH-1:0]         out_root_one,
  input logic [COEF_WIDTH-1:0]         out_root_two,
  input logic [COEF_WIDTH-1:0]         out_root_three,
  input logic [COEF_WIDTH-1:0]         out_root_four
);

  import qbs_pkg::*;

  logic in_accept;
  logic no_roots;
  logic count_ok;

  assign in_accept = start & ~busy;

  // empty root set: zero count and every root field zero
  assign no_roots = (out_root_count == '0) && (out_root_one == '0) &&
                    (out_root_two == '0) && (out_root_three == '0) &&
                    (out_root_four == '0);

  // count in range, fourth root zero unless all four are used
  assign count_ok = (out_root_count <= 3'd4) &&
                    ((out_root_count == 3'd4) || (out_root_four == '0));

  // every request yields a result after the fixed latency
  `QBS_ASSERT_DELAY(a_request_to_result, clk, rst_n, in_accept, LATENCY, out_valid)

  // no result without a request at the matching cycle
  `QBS_ASSERT_IMPLY(a_result_from_request, clk, rst_n, out_valid, $past(in_accept, LATENCY))

  // no-solution and every-x results carry no roots
  `QBS_ASSERT_IMPLY(a_nonfinite_empty, clk, rst_n, out_valid && out_outcome != OUT_FINITE, no_roots)

  // count stays in range and an unused fourth root reads zero
  `QBS_ASSERT_IMPLY(a_count_fourth, clk, rst_n, out_valid, count_ok)

endmodule

bind quadratic_biquadratic_solver_core qbs_prop_chk #(
  .COEF_WIDTH (COEF_WIDTH),
  .LATENCY    (LATENCY)
) u_qbs_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_outcome    (out_outcome),
  .out_root_count (out_root_count),
  .out_root_one   (out_root_one),
  .out_root_two   (out_root_two),
  .out_root_three (out_root_three),
  .out_root_four  (out_root_four)
);

`default_nettype wire
